>>> design/dqtl_pkg.sv
// shared types and constants of the delta queue task list
package dqtl_pkg;

  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int unsigned ID_W      = 8;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_POP_HEAD  = 2'd1,
    REQ_REMOVE_ID = 2'd2,
    REQ_NOP       = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_REPORT
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    out_task_id;
    logic [TIME_W-1:0]  out_period;
    logic [TIME_W-1:0]  out_delay;
    logic [TIME_W-1:0]  head_delay;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] delay;
  } entry_t;

  typedef struct packed {
    logic    ready;
    logic    load;
    logic    step;
    logic    ins;
    logic    rem;
    logic    finish;
    status_e status;
    logic    report;
  } cmd_t;

  typedef struct packed {
    req_e kind;
    logic full;
    logic empty;
    logic walk_end;
    logic ins_stop;
    logic id_hit;
    logic out_free;
  } stat_t;

endpackage

>>> design/delta_queue_task_list_core.sv
// top level of the delta queue task list: delta-ordered task queue with insert and removal
// a request is loaded in idle, walks n entries (0 to 16) in the walk state, then is reported into the output register
// insert walks up to the insertion point, remove by id up to the matching entry, one per cycle
// remove head and request type 3 finish in their first walk state; one request is in progress at a time
// the next request is taken while the previous result still waits in the output register
// reset clears the entry count and the output valid; entry contents are undefined until written
module delta_queue_task_list_core import dqtl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  dqtl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dqtl_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_data_i),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !cmd.ready;

endmodule

>>> design/dqtl_ctrl.sv
// sequencing state machine of the delta queue task list
module dqtl_ctrl import dqtl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // walk finished for the current request
  logic done;

  always_comb begin
    done = 1'b0;
    case (stat_i.kind)
      REQ_INSERT:    done = stat_i.full || stat_i.walk_end || stat_i.ins_stop;
      REQ_POP_HEAD:  done = 1'b1;
      REQ_REMOVE_ID: done = stat_i.empty || stat_i.walk_end || stat_i.id_hit;
      REQ_NOP:       done = 1'b1;
      default:       done = 1'b1;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_WALK;
      end
      S_WALK: begin
        if (done) state_d = S_REPORT;
      end
      S_REPORT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.status = ST_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.ready = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      S_WALK: begin
        cmd_o.finish = done;
        case (stat_i.kind)
          REQ_INSERT: begin
            if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else if (stat_i.walk_end || stat_i.ins_stop) begin
              cmd_o.ins = 1'b1;
            end else begin
              cmd_o.step = 1'b1;
            end
          end
          REQ_POP_HEAD: begin
            if (stat_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.rem = 1'b1;
            end
          end
          REQ_REMOVE_ID: begin
            if (stat_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else if (stat_i.walk_end) begin
              cmd_o.status = ST_NOT_FOUND;
            end else if (stat_i.id_hit) begin
              cmd_o.rem = 1'b1;
            end else begin
              cmd_o.step = 1'b1;
            end
          end
          default: cmd_o.status = ST_OK;
        endcase
      end
      S_REPORT: begin
        cmd_o.report = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> design/dqtl_dpath.sv
// entry store, walk registers and result register of the delta queue task list
module dqtl_dpath import dqtl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  req_t  req_i,
  input  logic  out_stall_i,
  output stat_t stat_o,
  output logic  out_valid_o,
  output res_t  out_data_o
);

  entry_t            store_q [MAX_TASKS];
  entry_t            store_d [MAX_TASKS];
  logic [CNT_W-1:0]  count_q, count_d;
  req_e              kind_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] per_q;
  logic [CNT_W-1:0]  pos_q;
  status_e           status_q;
  logic [ID_W-1:0]   oid_q;
  logic [TIME_W-1:0] oper_q;
  logic [TIME_W-1:0] odel_q;
  res_t              out_q;
  logic              out_valid_q, out_valid_d;

  entry_t            cur;
  entry_t            nxt;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat_sum;
  logic              rem_add;

  assign cur     = store_q[pos_q[IDX_W-1:0]];
  assign nxt     = store_q[IDX_W'(pos_q + CNT_W'(1))];
  assign sum     = {1'b0, nxt.delay} + {1'b0, cur.delay};
  assign sat_sum = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign rem_add = (kind_q == REQ_REMOVE_ID);

  assign stat_o.kind     = kind_q;
  assign stat_o.full     = (count_q >= CNT_W'(MAX_TASKS));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.walk_end = (pos_q >= count_q);
  assign stat_o.ins_stop = (rem_q < cur.delay);
  assign stat_o.id_hit   = (cur.id == id_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    store_d = store_q;
    count_d = count_q;
    if (cmd_i.ins) begin
      for (int i = 0; i < int'(MAX_TASKS); i++) begin
        if (CNT_W'(i) == pos_q) begin
          store_d[i] = '{id: id_q, period: per_q, delay: rem_q};
        end else if (CNT_W'(i) > pos_q && CNT_W'(i) <= count_q) begin
          if (CNT_W'(i) == pos_q + CNT_W'(1)) begin
            store_d[i]       = cur;
            store_d[i].delay = cur.delay - rem_q;
          end else begin
            store_d[i] = store_q[i-1];
          end
        end
      end
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.rem) begin
      for (int i = 0; i < int'(MAX_TASKS) - 1; i++) begin
        if (CNT_W'(i) >= pos_q && CNT_W'(i) + CNT_W'(1) < count_q) begin
          store_d[i] = store_q[i+1];
          if (CNT_W'(i) == pos_q && rem_add) store_d[i].delay = sat_sum;
        end
      end
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.report) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    if (cmd_i.load) begin
      kind_q <= req_e'(req_i.req_type);
      id_q   <= req_i.task_id;
      rem_q  <= req_i.delay;
      per_q  <= req_i.period;
      pos_q  <= '0;
    end else if (cmd_i.step) begin
      pos_q <= pos_q + CNT_W'(1);
      if (kind_q == REQ_INSERT) rem_q <= rem_q - cur.delay;
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      if (cmd_i.rem) begin
        oid_q  <= cur.id;
        oper_q <= cur.period;
        odel_q <= cur.delay;
      end else begin
        oid_q  <= '0;
        oper_q <= '0;
        odel_q <= '0;
      end
    end
    if (cmd_i.report) begin
      out_q.status      <= status_q;
      out_q.out_task_id <= oid_q;
      out_q.out_period  <= oper_q;
      out_q.out_delay   <= odel_q;
      out_q.head_delay  <= (count_q != '0) ? store_q[0].delay : '0;
      out_q.entry_count <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/dqtl_chk.sv
// port checker of the delta queue task list and its bind
module dqtl_chk import dqtl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input res_t out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // count never exceeds capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= COUNT_W'(MAX_TASKS))
    else $error("entry count above capacity");

  // full report only at capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.entry_count == COUNT_W'(MAX_TASKS))
    else $error("full status below capacity");

  // empty report shows an empty queue
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.entry_count == '0 && out_data_o.head_delay == '0)
    else $error("empty status with queued entries");

  // a request transfer makes the input busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

endmodule

bind delta_queue_task_list_core dqtl_chk u_dqtl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
